/* src/wlh_pkg.sv */
// Shared constants, types and command/status structs for the word length histogram.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package wlh_pkg;

	// Histogram geometry.
	localparam int unsigned MAX_WORD_LEN = 32;
	localparam int unsigned COUNT_BITS   = 20;
	localparam int unsigned NBINS        = MAX_WORD_LEN + 1;
	localparam int unsigned LEN_BITS     = $clog2(MAX_WORD_LEN + 2);
	localparam int unsigned BIN_BITS     = $clog2(MAX_WORD_LEN);
	localparam int unsigned LIMIT_BITS   = 8;
	localparam int unsigned BAR_BITS     = 8;
	localparam int unsigned STEP_BITS    = $clog2(COUNT_BITS + 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [LIMIT_BITS-1:0] BAR_LIMIT_RESET = 8'd16;

	// Character codes.
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

	// Input word kinds carried on tuser.
	localparam logic FUNC_TEXT = 1'b0;
	localparam logic FUNC_END  = 1'b1;

	// Output tdata layout, lowest field first.
	localparam int unsigned LEN_LSB   = 0;
	localparam int unsigned CNT_LSB   = LEN_LSB + LEN_BITS;
	localparam int unsigned BAR_LSB   = CNT_LSB + COUNT_BITS;
	localparam int unsigned SCALE_LSB = BAR_LSB + BAR_BITS;
	localparam int unsigned COLS_LSB  = SCALE_LSB + COUNT_BITS;
	localparam int unsigned OUT_USED  = COLS_LSB + LEN_BITS;
	localparam int unsigned OUT_TDATA_BITS = ((OUT_USED + 7) / 8) * 8;

	// Controller states, one-hot.
	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_FLUSH = 9'b000000010,
		ST_SCALE = 9'b000000100,
		ST_DIV1  = 9'b000001000,
		ST_DIV2  = 9'b000010000,
		ST_READ  = 9'b000100000,
		ST_START = 9'b001000000,
		ST_DIVB  = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;         // input word accepted this cycle
		logic scale_one;    // scale is 1, largest count fits the limit
		logic start_lim;    // divide largest count by the bar limit
		logic start_scale;  // load scale from quotient, divide largest count by it
		logic scale_adjust; // bump scale if largest/scale still exceeds the limit
		logic bin_first;    // point the dump at the first bin
		logic bin_next;     // advance the dump to the next bin
		logic bin_read;     // read the current bin
		logic start_bin;    // divide the current bin count by the scale
		logic out_load;     // load the output register
		logic dump_clear;   // clear all histogram state
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic large_gt_lim; // largest count exceeds the bar limit
		logic div_busy;     // divider still iterating
		logic out_done;     // output word taken this cycle
		logic bin_last;     // current bin is the overflow bin
	} dp_status_t;

endpackage

/* src/wlh_div.sv */
// Serial restoring divider, one quotient bit per cycle.
// Depends on wlh_pkg for the count width.
`timescale 1ns / 1ps

module wlh_div
	import wlh_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [COUNT_BITS-1:0] dividend,
	input  logic [COUNT_BITS-1:0] divisor,
	output logic                  busy,
	output logic [COUNT_BITS-1:0] quotient
);

	logic [STEP_BITS-1:0]  step_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] quo_q;
	logic [COUNT_BITS-1:0] divisor_q;
	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS:0]   diff;
	logic                  fits;

	// One trial subtraction of the shifted remainder.
	always_comb begin
		trial = {rem_q, quo_q[COUNT_BITS-1]};
		diff  = trial - {1'b0, divisor_q};
		fits  = trial >= {1'b0, divisor_q};
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= STEP_BITS'(COUNT_BITS);
		end else if (step_q != '0) begin
			step_q <= step_q - 1'b1;
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (step_q != '0) begin
			rem_q <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			quo_q <= {quo_q[COUNT_BITS-2:0], fits};
		end
	end

	assign busy     = step_q != '0;
	assign quotient = quo_q;

endmodule

/* src/wlh_datapath.sv */
// Datapath: word tracking, bin memory, scale computation and output register.
// Depends on wlh_pkg and instantiates wlh_div.
`timescale 1ns / 1ps

module wlh_datapath
	import wlh_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  dp_cmd_t                   cmd,
	output dp_status_t                status,
	input  logic [7:0]                s_tdata,
	input  logic                      s_tuser,
	input  logic                      cfg_we,
	input  logic [LIMIT_BITS-1:0]     cfg_data,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_TDATA_BITS-1:0] m_tdata,
	output logic                      m_tlast
);

	logic [LIMIT_BITS-1:0] bar_limit_q;
	logic                  in_word_q;
	logic [LEN_BITS-1:0]   letter_count_q;
	logic [COUNT_BITS-1:0] overflow_q;
	logic [COUNT_BITS-1:0] largest_q;
	logic [LEN_BITS-1:0]   highest_q;
	logic [COUNT_BITS-1:0] bins_mem [MAX_WORD_LEN];
	logic [MAX_WORD_LEN-1:0] bin_vld_q;
	logic [COUNT_BITS-1:0] rd_q;
	logic                  rd_vld_q;
	logic                  upd_s1;
	logic                  upd_ovf_s1;
	logic [BIN_BITS-1:0]   upd_addr_s1;
	logic [LEN_BITS-1:0]   bin_q;
	logic [COUNT_BITS-1:0] scale_q;
	logic                  out_vld_q;
	logic [OUT_TDATA_BITS-1:0] out_data_q;
	logic                  out_last_q;

	logic                  is_letter;
	logic                  end_word;
	logic                  long_word;
	logic [BIN_BITS-1:0]   end_addr;
	logic                  rd_en;
	logic [BIN_BITS-1:0]   rd_addr;
	logic [COUNT_BITS-1:0] bin_cnt;
	logic [COUNT_BITS-1:0] upd_base;
	logic [COUNT_BITS-1:0] upd_new;
	logic [LIMIT_BITS-1:0] lim;
	logic [LEN_BITS-1:0]   cols;
	logic                  div_start;
	logic [COUNT_BITS-1:0] div_dividend;
	logic [COUNT_BITS-1:0] div_divisor;
	logic                  div_busy;
	logic [COUNT_BITS-1:0] div_quo;
	logic [OUT_TDATA_BITS-1:0] out_word;

	// Classify the incoming byte and detect the end of a word.
	always_comb begin
		is_letter = s_tdata inside {[CHAR_UPPER_A:CHAR_UPPER_Z], [CHAR_LOWER_A:CHAR_LOWER_Z]};
		end_word  = cmd.take && in_word_q && (s_tuser == FUNC_END || !is_letter);
		long_word = letter_count_q > LEN_BITS'(MAX_WORD_LEN);
		end_addr  = BIN_BITS'(letter_count_q - 1'b1);
		rd_en     = end_word || cmd.bin_read;
		rd_addr   = cmd.bin_read ? bin_q[BIN_BITS-1:0] : end_addr;
	end

	// Bar limit register; zero acts as one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_limit_q <= BAR_LIMIT_RESET;
		end else if (cfg_we) begin
			bar_limit_q <= cfg_data;
		end
	end
	assign lim = (bar_limit_q == '0) ? LIMIT_BITS'(1) : bar_limit_q;

	// Letter run tracking and the update stage that follows a word end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q      <= 1'b0;
			letter_count_q <= '0;
			upd_s1         <= 1'b0;
			highest_q      <= '0;
		end else begin
			upd_s1 <= end_word;
			if (cmd.dump_clear) begin
				highest_q <= '0;
			end else if (end_word && !long_word && letter_count_q > highest_q) begin
				highest_q <= letter_count_q;
			end
			if (cmd.take) begin
				if (s_tuser == FUNC_TEXT && is_letter) begin
					in_word_q <= 1'b1;
					if (!long_word) begin
						letter_count_q <= letter_count_q + 1'b1;
					end
				end else begin
					in_word_q      <= 1'b0;
					letter_count_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (end_word) begin
			upd_ovf_s1  <= long_word;
			upd_addr_s1 <= end_addr;
		end
	end

	// Bin memory: one registered read port, one write port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= bins_mem[rd_addr];
		end
		if (upd_s1 && !upd_ovf_s1) begin
			bins_mem[upd_addr_s1] <= upd_new;
		end
	end

	// Valid bits: an entry never written since the last clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld_q <= bin_vld_q[rd_addr];
			end
			if (cmd.dump_clear) begin
				bin_vld_q <= '0;
			end else if (upd_s1 && !upd_ovf_s1) begin
				bin_vld_q[upd_addr_s1] <= 1'b1;
			end
		end
	end

	// Saturating increment of the bin picked by the ended word.
	always_comb begin
		upd_base = upd_ovf_s1 ? overflow_q : (rd_vld_q ? rd_q : '0);
		upd_new  = (upd_base == COUNT_MAX) ? upd_base : upd_base + 1'b1;
	end

	// Overflow bin and largest count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overflow_q <= '0;
			largest_q  <= '0;
		end else if (cmd.dump_clear) begin
			overflow_q <= '0;
			largest_q  <= '0;
		end else if (upd_s1) begin
			if (upd_ovf_s1) begin
				overflow_q <= upd_new;
			end
			if (upd_new > largest_q) begin
				largest_q <= upd_new;
			end
		end
	end

	// Dump bin pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q <= '0;
		end else if (cmd.bin_first) begin
			bin_q <= '0;
		end else if (cmd.bin_next) begin
			bin_q <= bin_q + 1'b1;
		end
	end

	// Count of the bin being dumped.
	assign bin_cnt = (bin_q == LEN_BITS'(MAX_WORD_LEN)) ? overflow_q
		: (rd_vld_q ? rd_q : '0);

	// Divider operand selection.
	always_comb begin
		div_start    = cmd.start_lim || cmd.start_scale || cmd.start_bin;
		div_dividend = cmd.start_bin ? bin_cnt : largest_q;
		if (cmd.start_lim) begin
			div_divisor = COUNT_BITS'(lim);
		end else if (cmd.start_scale) begin
			div_divisor = div_quo;
		end else begin
			div_divisor = scale_q;
		end
	end

	wlh_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// Scale register.
	always_ff @(posedge clk) begin
		if (cmd.scale_one) begin
			scale_q <= COUNT_BITS'(1);
		end else if (cmd.start_scale) begin
			scale_q <= div_quo;
		end else if (cmd.scale_adjust && div_quo > COUNT_BITS'(lim)) begin
			scale_q <= scale_q + 1'b1;
		end
	end

	// Columns shown: every bin once the overflow bin is used.
	assign cols = (overflow_q != '0) ? LEN_BITS'(NBINS) : highest_q;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Pack the dump word, zero fill above the last field.
	always_comb begin
		out_word = '0;
		out_word[LEN_LSB +: LEN_BITS]     = bin_q + 1'b1;
		out_word[CNT_LSB +: COUNT_BITS]   = bin_cnt;
		out_word[BAR_LSB +: BAR_BITS]     = div_quo[BAR_BITS-1:0];
		out_word[SCALE_LSB +: COUNT_BITS] = scale_q;
		out_word[COLS_LSB +: LEN_BITS]    = cols;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= out_word;
			out_last_q <= bin_q == LEN_BITS'(MAX_WORD_LEN);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// Status back to the controller.
	always_comb begin
		status.large_gt_lim = largest_q > COUNT_BITS'(lim);
		status.div_busy     = div_busy;
		status.out_done     = out_vld_q && m_tready;
		status.bin_last     = bin_q == LEN_BITS'(MAX_WORD_LEN);
	end

endmodule

/* src/wlh_ctrl.sv */
// Controller state machine: input acceptance, scale computation and the bin dump.
// Depends on wlh_pkg for states and the command/status structs.
`timescale 1ns / 1ps

module wlh_ctrl
	import wlh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic       s_tuser,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q;
	state_t state_nx;

	// Next state and commands.
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		s_tready = state_q == ST_IDLE;
		case (state_q)
			ST_IDLE: begin
				cmd.take = s_tvalid;
				if (s_tvalid && s_tuser == FUNC_END) begin
					state_nx = ST_FLUSH;
				end
			end
			// Let the last word's bin update land.
			ST_FLUSH: begin
				state_nx = ST_SCALE;
			end
			ST_SCALE: begin
				if (status.large_gt_lim) begin
					cmd.start_lim = 1'b1;
					state_nx      = ST_DIV1;
				end else begin
					cmd.scale_one = 1'b1;
					cmd.bin_first = 1'b1;
					state_nx      = ST_READ;
				end
			end
			ST_DIV1: begin
				if (!status.div_busy) begin
					cmd.start_scale = 1'b1;
					state_nx        = ST_DIV2;
				end
			end
			ST_DIV2: begin
				if (!status.div_busy) begin
					cmd.scale_adjust = 1'b1;
					cmd.bin_first    = 1'b1;
					state_nx         = ST_READ;
				end
			end
			ST_READ: begin
				cmd.bin_read = 1'b1;
				state_nx     = ST_START;
			end
			ST_START: begin
				cmd.start_bin = 1'b1;
				state_nx      = ST_DIVB;
			end
			ST_DIVB: begin
				if (!status.div_busy) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_OUT;
				end
			end
			ST_OUT: begin
				if (status.out_done) begin
					if (status.bin_last) begin
						cmd.dump_clear = 1'b1;
						state_nx       = ST_IDLE;
					end else begin
						cmd.bin_next = 1'b1;
						state_nx     = ST_READ;
					end
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

/* src/word_length_histogram_top.sv */
// Word length histogram: text words are taken while idle; an end-of-text word starts a dump.
// The dump first sets the scale to one, or with scaling derives it from two divider runs,
// then emits 33 bins, each taking a read, a start, a divider run and the output handshake.
// Output stalls lengthen a dump; no input is taken during it.
// Asynchronous active-low reset clears all counts and sets the bar limit to 16.
`timescale 1ns / 1ps

module word_length_histogram_top
	import wlh_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,   // text_byte
	input  logic                      s_tuser,   // func
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// word_length, word_count, bar_height, scale_factor, shown_columns, zero fill
	output logic [OUT_TDATA_BITS-1:0] m_tdata,
	output logic                      m_tlast,   // last_bin
	input  logic                      cfg_we,
	input  logic [LIMIT_BITS-1:0]     cfg_data   // bar_limit
);

	dp_cmd_t    cmd;
	dp_status_t status;

	wlh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.status   (status),
		.cmd      (cmd)
	);

	wlh_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Input is never taken while a dump word is pending.
	a_no_input_during_dump: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input ready while a dump word is pending");

	// Taking the last bin returns the block to accepting text.
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready)
		else $error("block not idle after the last bin");

	// The scale is never zero.
	a_scale_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[SCALE_LSB +: COUNT_BITS] != '0)
		else $error("zero scale factor");

	// The last mark sits on the overflow bin.
	a_last_is_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[LEN_LSB +: LEN_BITS] == LEN_BITS'(NBINS))
		else $error("last mark not on the overflow bin");

endmodule

/* tb/tb_word_length_histogram_top.sv */
// Self-checking bench for word_length_histogram_top: it streams text bytes and end-of-text
// words, and compares every dumped bin against an in-bench histogram. Depends on wlh_pkg.
`timescale 1ns / 1ps

module tb_word_length_histogram_top;
	import wlh_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 350;
	localparam int unsigned CALM_ITEMS   = 60;
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam int unsigned CYCLE_LIMIT  = 2000000;

	// One dumped bin, as the block should present it.
	typedef struct {
		logic [LEN_BITS-1:0]   length;
		logic [COUNT_BITS-1:0] count;
		logic [BAR_BITS-1:0]   bar;
		logic [COUNT_BITS-1:0] scale;
		logic [LEN_BITS-1:0]   columns;
		logic                  last;
	} bin_word_t;

	// Running histogram of the text seen so far and the bins that a dump must produce.
	class word_histogram;
		logic [LIMIT_BITS-1:0] bar_limit;
		logic                  open_word;
		logic [LEN_BITS-1:0]   run_len;
		logic [COUNT_BITS-1:0] len_count [MAX_WORD_LEN];
		logic [COUNT_BITS-1:0] overflow_count;
		logic [COUNT_BITS-1:0] peak_count;
		logic [LEN_BITS-1:0]   longest_used;
		bin_word_t             pending_bins [$];
		int                    errors;

		function new();
			bar_limit = BAR_LIMIT_RESET;
			errors = 0;
			clear_counts();
		endfunction

		function void clear_counts();
			open_word = 1'b0;
			run_len = '0;
			foreach (len_count[k])
				len_count[k] = '0;
			overflow_count = '0;
			peak_count = '0;
			longest_used = '0;
		endfunction

		// Saturating increment that also tracks the largest bin.
		function logic [COUNT_BITS-1:0] add_one(logic [COUNT_BITS-1:0] c);
			if (c != COUNT_MAX)
				c = c + 1'b1;
			if (c > peak_count)
				peak_count = c;
			return c;
		endfunction

		function void close_word();
			if (open_word && run_len > 0) begin
				if (run_len <= MAX_WORD_LEN) begin
					len_count[run_len-1] = add_one(len_count[run_len-1]);
					if (run_len > longest_used)
						longest_used = run_len;
				end else begin
					overflow_count = add_one(overflow_count);
				end
			end
			open_word = 1'b0;
			run_len = '0;
		endfunction

		// Called for every accepted input word.
		function void count_item(logic func, logic [7:0] text_byte);
			logic [7:0]  ch;
			int unsigned lim;
			int unsigned scl;
			int unsigned cols;
			int unsigned cnt;
			bin_word_t   b;
			if (func == FUNC_TEXT) begin
				ch = text_byte;
				if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z)
					ch = ch - CHAR_UPPER_A + CHAR_LOWER_A;
				if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
					open_word = 1'b1;
					if (run_len <= MAX_WORD_LEN)
						run_len = run_len + 1'b1;
				end else begin
					close_word();
				end
				return;
			end
			close_word();
			// A zero limit behaves as one; the scale is rounded up so no bar exceeds it.
			lim = (bar_limit == 0) ? 1 : 32'(bar_limit);
			scl = 1;
			if (32'(peak_count) > lim) begin
				scl = 32'(peak_count) / lim;
				if (32'(peak_count) / scl > lim)
					scl = scl + 1;
			end
			cols = (overflow_count != 0) ? NBINS : 32'(longest_used);
			for (int k = 0; k < NBINS; k++) begin
				cnt = (k < MAX_WORD_LEN) ? 32'(len_count[k]) : 32'(overflow_count);
				b.length = LEN_BITS'(k + 1);
				b.count = COUNT_BITS'(cnt);
				b.bar = BAR_BITS'(cnt / scl);
				b.scale = COUNT_BITS'(scl);
				b.columns = LEN_BITS'(cols);
				b.last = (k == NBINS - 1);
				pending_bins.push_back(b);
			end
			clear_counts();
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		// Called for every accepted output word.
		function void check_bin(logic [OUT_TDATA_BITS-1:0] d, logic tlast);
			bin_word_t b;
			if (pending_bins.size() == 0) begin
				$display("%0t ns: output word %h with tlast %b arrived with none expected",
					$time, d, tlast);
				errors++;
				return;
			end
			b = pending_bins.pop_front();
			compare_field("word_length", 32'(b.length), 32'(d[LEN_LSB +: LEN_BITS]));
			compare_field("word_count", 32'(b.count), 32'(d[CNT_LSB +: COUNT_BITS]));
			compare_field("bar_height", 32'(b.bar), 32'(d[BAR_LSB +: BAR_BITS]));
			compare_field("scale_factor", 32'(b.scale), 32'(d[SCALE_LSB +: COUNT_BITS]));
			compare_field("shown_columns", 32'(b.columns), 32'(d[COLS_LSB +: LEN_BITS]));
			compare_field("zero fill", 32'(0), 32'(d >> OUT_USED));
			compare_field("last_bin", 32'(b.last), 32'(tlast));
		endfunction

		function int unsigned pending();
			return pending_bins.size();
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [7:0]                s_tdata;
	logic                      s_tuser;
	logic                      m_tvalid;
	logic                      m_tready;
	logic [OUT_TDATA_BITS-1:0] m_tdata;
	logic                      m_tlast;
	logic                      cfg_we;
	logic [LIMIT_BITS-1:0]     cfg_data;

	word_histogram hist = new();
	bit            idling_on = 1'b1;
	bit            sender_gaps = 1'b1;
	int unsigned   items_sent = 0;
	int unsigned   cycle_count = 0;

	word_length_histogram_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: a hang or a lost word ends the run here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// Both handshakes are observed at the rising edge, input side first.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				hist.count_item(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				hist.check_bin(m_tdata, m_tlast);
		end
	end

	// Output side: ready stretches and stall bursts follow in random order while idling is on.
	initial begin
		int unsigned hold;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (idling_on && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				hold = $urandom_range(1, 13);
			end else begin
				m_tready <= 1'b1;
				hold = $urandom_range(1, 24);
			end
			repeat (hold - 1) @(negedge clk);
		end
	end

	function automatic logic [7:0] random_letter();
		logic [7:0] base;
		logic [7:0] offset;
		base = $urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A;
		offset = 8'($urandom_range(0, 25));
		return base + offset;
	endfunction

	function automatic logic [7:0] random_separator();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b inside {[CHAR_UPPER_A:CHAR_UPPER_Z], [CHAR_LOWER_A:CHAR_LOWER_Z]});
		return b;
	endfunction

	// Presents one input word and returns just after the falling edge that follows its acceptance.
	task automatic send_item(logic func, logic [7:0] text_byte);
		int unsigned gap;
		if (idling_on && sender_gaps && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 13);
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= text_byte;
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
		@(negedge clk);
	endtask

	// Waits until the dump in flight has been fully read, then lets the block settle.
	task automatic wait_for_dump_done();
		s_tvalid <= 1'b0;
		while (hist.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_bar_limit(logic [LIMIT_BITS-1:0] value);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		hist.bar_limit = value;
	endtask

	// Stimulus: directed text first, then random phases that each end in a dump.
	initial begin
		logic [7:0]            mixed_text [15];
		logic [LIMIT_BITS-1:0] lim;
		int unsigned           n_words;
		int unsigned           wlen;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = FUNC_TEXT;
		cfg_we = 1'b0;
		cfg_data = '0;
		// Letters at both ends of each case range, split by the bytes just outside them.
		mixed_text = '{8'h41, 8'h7A, 8'h40, 8'h5A, 8'h5B, 8'h61, 8'h60, 8'h7B,
			8'h62, 8'h27, 8'h63, 8'h00, 8'h71, 8'h80, 8'h4D};
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty text under the reset bar limit.
		send_item(FUNC_END, 8'hFF);
		wait_for_dump_done();

		// Smallest limit, so the single-letter bin forces a scale; the last word stays open.
		write_bar_limit(8'd1);
		foreach (mixed_text[i])
			send_item(FUNC_TEXT, mixed_text[i]);
		send_item(FUNC_END, 8'h00);
		wait_for_dump_done();

		// Largest limit, word closed by a space before the end.
		write_bar_limit(8'd255);
		send_item(FUNC_TEXT, 8'h78);
		send_item(FUNC_TEXT, 8'h59);
		send_item(FUNC_TEXT, 8'h20);
		send_item(FUNC_END, 8'h55);

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			wait_for_dump_done();
			case ($urandom_range(0, 5))
				0: lim = 8'd0;
				1: lim = 8'd1;
				2: lim = 8'd255;
				3: lim = LIMIT_BITS'($urandom_range(2, 4));
				default: lim = LIMIT_BITS'($urandom_range(1, 255));
			endcase
			write_bar_limit(lim);
			if (items_sent + CALM_ITEMS >= RANDOM_ITEMS)
				idling_on = 1'b0;
			sender_gaps = ($urandom_range(0, 3) != 0);
			n_words = $urandom_range(1, 12);
			repeat (n_words) begin
				if ($urandom_range(0, 9) == 0) begin
					send_item(FUNC_TEXT, 8'($urandom_range(0, 255)));
				end else begin
					// Mostly short words; now and then one near or past the longest bin.
					wlen = ($urandom_range(0, 15) == 0) ? $urandom_range(31, 40)
						: $urandom_range(1, 6);
					repeat (wlen) send_item(FUNC_TEXT, random_letter());
					send_item(FUNC_TEXT, random_separator());
					if ($urandom_range(0, 7) == 0)
						send_item(FUNC_TEXT, random_separator());
				end
			end
			if ($urandom_range(0, 2) == 0) begin
				wlen = $urandom_range(1, 5);
				repeat (wlen) send_item(FUNC_TEXT, random_letter());
			end
			send_item(FUNC_END, 8'($urandom_range(0, 255)));
		end
		wait_for_dump_done();

		if (hist.errors == 0 && hist.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
